@@ rtl/ptick_pkg.sv @@
// ----------------------------------------------------------------------------
// ptick_pkg
// Shared widths, opcodes and register indexes of the periodic ticker.
// ----------------------------------------------------------------------------
package ptick_pkg;

   localparam int TIME_W     = 63;             // time fields on the ports
   localparam int WORD_W     = 64;             // internal two's complement time
   localparam int OP_W       = 3;
   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 136;
   localparam int CSR_IDX_W  = 1;
   localparam int DIV_STEPS  = WORD_W;         // one quotient bit per step
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic [OP_W-1:0] OP_CHECK   = 3'd0;
   localparam logic [OP_W-1:0] OP_ON      = 3'd1;
   localparam logic [OP_W-1:0] OP_OFF     = 3'd2;
   localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
   localparam logic [OP_W-1:0] OP_RESYNC  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_LEAD   = 1'b1;

   localparam logic [TIME_W-1:0] PERIOD_RESET = 63'd75000000000;
   localparam logic [TIME_W-1:0] LEAD_RESET   = 63'd0;

endpackage

@@ rtl/periodic_tick_with_prewarning.sv @@
// ----------------------------------------------------------------------------
// periodic_tick_with_prewarning
// Free-running tick with one pre-warning per period on absolute ns time.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  req     | in        | req_tvalid/req_tready  | tdata: now, tick_offset
//          |           |                        | tuser: opcode, has_offset
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: flags, deadline, ttt,
//          |           |                        |        ticker_on
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
//  A request runs through the 64 restoring divider steps and through
//  further sequencer steps on the one shared 65-bit add/subtract/compare
//  unit. req_tready is high only in idle.
//  A finished response sits in the output register; the next request is
//  taken meanwhile and only its final step waits for rsp_tready.
//  Reset is synchronous: origins, enable and registers return to defaults.
//
module periodic_tick_with_prewarning (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [62:0] now, [125:63] tick_offset, [127:126] zero
   input  logic [ptick_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [2:0] opcode, [3] has_offset
   input  logic [ptick_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] tick_fired, [1] prewarn_fired, [64:2] next_deadline,
   // [127:65] time_to_tick, [128] ticker_on, [135:129] zero
   output logic [ptick_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ptick_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ptick_pkg::TIME_W-1:0]          csr_data
);
   import ptick_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_ON_A, S_ON_B, S_ON_C, S_ON_D, S_ON_E, S_RS_A, S_RS_B,
      S_DIFF, S_ABS, S_DIV, S_RNEG, S_TTT, S_WA,
      S_CK_A, S_CK_B, S_CK_T, S_CK_W1, S_CK_W2, S_CK_W3,
      S_DL_A, S_DL_B, S_DL_C, S_DL_D, S_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [TIME_W-1:0]   period_ff, period_in;
   logic [TIME_W-1:0]   lead_ff, lead_in;
   logic [WORD_W-1:0]   origin_ff, origin_in;
   logic [WORD_W-1:0]   warned_org_ff, warned_org_in;
   logic                en_ff, en_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [WORD_W-1:0]   now_ff, now_in;
   logic                has_off_ff, has_off_in;
   logic [WORD_W-1:0]   off_ff, off_in;
   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic [WORD_W-1:0]   tmp_ff, tmp_in;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]   dvd_ff, dvd_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic                wa_ff, wa_in;
   logic                fired_ff, fired_in;
   logic                warned_ff, warned_in;
   logic [TIME_W-1:0]   ttt_ff, ttt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared add/subtract/compare unit, operands extended to 65 bits
   logic [WORD_W-1:0]   alu_a, alu_b;
   logic                alu_sub, alu_sgn;
   logic [WORD_W:0]     alu_ax, alu_bx, alu_res;

   logic [WORD_W-1:0]   p_ext, lead_ext, shifted;
   logic [TIME_W-1:0]   dl_out;

   assign p_ext    = (period_ff == '0) ? WORD_W'(1) : {1'b0, period_ff};
   assign lead_ext = {1'b0, lead_ff};
   assign shifted  = {rem_ff[WORD_W-2:0], dvd_ff[WORD_W-1]};

   assign alu_ax  = {alu_sgn & alu_a[WORD_W-1], alu_a};
   assign alu_bx  = {alu_sgn & alu_b[WORD_W-1], alu_b};
   assign alu_res = alu_sub ? (alu_ax - alu_bx) : (alu_ax + alu_bx);

   assign dl_out = tmp_ff[WORD_W-1] ? '0 : tmp_ff[TIME_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      period_in     = period_ff;
      lead_in       = lead_ff;
      origin_in     = origin_ff;
      warned_org_in = warned_org_ff;
      en_in         = en_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      has_off_in    = has_off_ff;
      off_in        = off_ff;
      acc_in        = acc_ff;
      tmp_in        = tmp_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      wa_in         = wa_ff;
      fired_in      = fired_ff;
      warned_in     = warned_ff;
      ttt_in        = ttt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      alu_a         = '0;
      alu_b         = '0;
      alu_sub       = 1'b0;
      alu_sgn       = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            REG_PERIOD: period_in = csr_data;
            REG_LEAD:   lead_in   = csr_data;
            default:    period_in = period_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tuser[OP_W-1:0];
               now_in     = {1'b0, req_tdata[TIME_W-1:0]};
               has_off_in = req_tuser[OP_W];
               off_in     = {1'b0, req_tdata[2*TIME_W-1:TIME_W]};
               fired_in   = 1'b0;
               warned_in  = 1'b0;
               case (req_tuser[OP_W-1:0])
                  OP_ON: begin
                     en_in    = 1'b1;
                     state_in = S_ON_A;
                  end
                  OP_OFF: begin
                     en_in    = 1'b0;
                     state_in = S_DIFF;
                  end
                  OP_RESTART: begin
                     origin_in     = {1'b0, req_tdata[TIME_W-1:0]};
                     warned_org_in = '0;
                     state_in      = S_DIFF;
                  end
                  OP_RESYNC: state_in = S_RS_A;
                  default:   state_in = S_DIFF;
               endcase
            end
         end
         // ticker on: origin from the offset, or now if it was zero, then mark the warning done if already due
         S_ON_A: begin
            if (has_off_ff) begin
               alu_a    = now_ff;
               alu_b    = p_ext;
               alu_sub  = 1'b1;
               acc_in   = alu_res[WORD_W-1:0];
               state_in = S_ON_B;
            end else begin
               if (origin_ff == '0) begin
                  origin_in = now_ff;
               end
               state_in = S_ON_C;
            end
         end
         S_ON_B: begin
            alu_a     = acc_ff;
            alu_b     = off_ff;
            origin_in = alu_res[WORD_W-1:0];
            state_in  = S_ON_C;
         end
         S_ON_C: begin
            alu_a    = origin_ff;
            alu_b    = p_ext;
            tmp_in   = alu_res[WORD_W-1:0];
            state_in = S_ON_D;
         end
         S_ON_D: begin
            alu_a    = tmp_ff;
            alu_b    = lead_ext;
            alu_sub  = 1'b1;
            tmp_in   = alu_res[WORD_W-1:0];
            state_in = S_ON_E;
         end
         S_ON_E: begin
            alu_a   = now_ff;
            alu_b   = tmp_ff;
            alu_sub = 1'b1;
            alu_sgn = 1'b1;
            if (!alu_res[WORD_W]) begin
               warned_org_in = origin_ff;
            end
            state_in = S_DIFF;
         end
         // pretick resync
         S_RS_A: begin
            alu_a    = now_ff;
            alu_b    = lead_ext;
            alu_sub  = 1'b1;
            acc_in   = alu_res[WORD_W-1:0];
            state_in = S_RS_B;
         end
         S_RS_B: begin
            alu_a         = acc_ff;
            alu_b         = origin_ff;
            alu_sub       = 1'b1;
            alu_sgn       = 1'b1;
            warned_org_in = alu_res[WORD_W] ? origin_ff : '0;
            state_in      = S_DIFF;
         end
         // signed remainder of (now - origin) by the period
         S_DIFF: begin
            alu_a    = now_ff;
            alu_b    = origin_ff;
            alu_sub  = 1'b1;
            acc_in   = alu_res[WORD_W-1:0];
            neg_in   = alu_res[WORD_W-1];
            state_in = S_ABS;
         end
         S_ABS: begin
            alu_b    = acc_ff;
            alu_sub  = 1'b1;
            dvd_in   = neg_ff ? alu_res[WORD_W-1:0] : acc_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            alu_a   = shifted;
            alu_b   = p_ext;
            alu_sub = 1'b1;
            rem_in  = alu_res[WORD_W] ? shifted : alu_res[WORD_W-1:0];
            dvd_in  = {dvd_ff[WORD_W-2:0], 1'b0};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_RNEG;
            end
         end
         S_RNEG: begin
            alu_b    = rem_ff;
            alu_sub  = 1'b1;
            acc_in   = neg_ff ? alu_res[WORD_W-1:0] : rem_ff;
            state_in = S_TTT;
         end
         S_TTT: begin
            // |r| < period, so a negative sum only needs bit 63 for saturation
            alu_a    = p_ext;
            alu_b    = rem_ff;
            alu_sub  = !neg_ff;
            ttt_in   = (neg_ff && alu_res[WORD_W-1]) ? '1 : alu_res[TIME_W-1:0];
            state_in = S_WA;
         end
         S_WA: begin
            alu_a    = lead_ext;
            alu_b    = p_ext;
            alu_sub  = 1'b1;
            wa_in    = alu_res[WORD_W] & en_ff;
            state_in = (op_ff == OP_CHECK) ? S_CK_A : S_DL_A;
         end
         // check: tick, else maybe the pre-warning
         S_CK_A: begin
            alu_a    = origin_ff;
            alu_b    = p_ext;
            tmp_in   = alu_res[WORD_W-1:0];
            state_in = S_CK_B;
         end
         S_CK_B: begin
            alu_a   = now_ff;
            alu_b   = tmp_ff;
            alu_sub = 1'b1;
            alu_sgn = 1'b1;
            if (!alu_res[WORD_W]) begin
               fired_in = en_ff;
               state_in = S_CK_T;
            end else if (wa_ff) begin
               state_in = S_CK_W1;
            end else begin
               state_in = S_DL_A;
            end
         end
         S_CK_T: begin
            alu_a     = now_ff;
            alu_b     = acc_ff;
            alu_sub   = 1'b1;
            origin_in = alu_res[WORD_W-1:0];
            state_in  = S_DL_A;
         end
         S_CK_W1: begin
            alu_a    = tmp_ff;
            alu_b    = lead_ext;
            alu_sub  = 1'b1;
            tmp_in   = alu_res[WORD_W-1:0];
            state_in = S_CK_W2;
         end
         S_CK_W2: begin
            alu_a    = now_ff;
            alu_b    = tmp_ff;
            alu_sub  = 1'b1;
            alu_sgn  = 1'b1;
            state_in = alu_res[WORD_W] ? S_DL_A : S_CK_W3;
         end
         S_CK_W3: begin
            alu_a   = warned_org_ff;
            alu_b   = origin_ff;
            alu_sub = 1'b1;
            alu_sgn = 1'b1;
            if (alu_res[WORD_W]) begin
               warned_in     = 1'b1;
               warned_org_in = origin_ff;
            end
            state_in = S_DL_A;
         end
         // next wake-up deadline
         S_DL_A: begin
            alu_a    = origin_ff;
            alu_b    = p_ext;
            tmp_in   = alu_res[WORD_W-1:0];
            state_in = S_DL_B;
         end
         S_DL_B: begin
            alu_a    = tmp_ff;
            alu_b    = now_ff;
            alu_sub  = 1'b1;
            acc_in   = alu_res[WORD_W-1:0];
            state_in = S_DL_C;
         end
         S_DL_C: begin
            alu_a    = lead_ext;
            alu_b    = acc_ff;
            alu_sub  = 1'b1;
            alu_sgn  = 1'b1;
            state_in = (alu_res[WORD_W] && wa_ff) ? S_DL_D : S_EMIT;
         end
         S_DL_D: begin
            alu_a    = tmp_ff;
            alu_b    = lead_ext;
            alu_sub  = 1'b1;
            tmp_in   = alu_res[WORD_W-1:0];
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, en_ff, ttt_ff, dl_out, warned_ff, fired_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      now_ff      <= now_in;
      has_off_ff  <= has_off_in;
      off_ff      <= off_in;
      acc_ff      <= acc_in;
      tmp_ff      <= tmp_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      wa_ff       <= wa_in;
      fired_ff    <= fired_in;
      warned_ff   <= warned_in;
      ttt_ff      <= ttt_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         period_ff     <= PERIOD_RESET;
         lead_ff       <= LEAD_RESET;
         origin_ff     <= '0;
         warned_org_ff <= '0;
         en_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         period_ff     <= period_in;
         lead_ff       <= lead_in;
         origin_ff     <= origin_in;
         warned_org_ff <= warned_org_in;
         en_ff         <= en_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

@@ verif/periodic_tick_with_prewarning_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_tick_with_prewarning_test
// Self-checking bench for the periodic ticker with pre-warning. A local model
// of the phase origin, the warning mark and the enable flag predicts every
// response; directed cases run, and tick sequences aimed at period boundaries
// and free random requests run under several backpressure mixes.
// ----------------------------------------------------------------------------
module periodic_tick_with_prewarning_test;
   import ptick_pkg::*;

   localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
   localparam logic [63:0] TIME_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int WATCHDOG_LIMIT          = 4000;
   localparam int HOLD_CYCLES             = 400;

   typedef struct {
      logic              tick_fired;
      logic              prewarn_fired;
      logic [TIME_W-1:0] next_deadline;
      logic [TIME_W-1:0] time_to_tick;
      logic              ticker_on;
   } tick_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [TIME_W-1:0]     csr_data = '0;

   // model state
   logic [TIME_W-1:0] period_reg = PERIOD_RESET;
   logic [TIME_W-1:0] lead_reg   = LEAD_RESET;
   logic [63:0]       origin_q   = '0;
   logic [63:0]       warned_origin_q = '0;
   logic              ticker_en_q = 1'b0;

   tick_outcome_type tick_outcomes_q[$];
   int fail_count     = 0;
   int quiet_cycles   = 0;
   int sender_gap_pct = 0;
   int rsp_stall_pct  = 0;
   int hold_left      = 0;
   logic hold_start   = 1'b0;
   logic [62:0] cur_now = '0;

   int gap_modes[4]   = '{0, 45, 0, 26};
   int stall_modes[4] = '{0, 0, 45, 26};

   periodic_tick_with_prewarning uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic logic [63:0] eff_period();
      return (period_reg == '0) ? 64'd1 : {1'b0, period_reg};
   endfunction

   // remainder of (t - origin) by p, carrying the sign of the difference
   function automatic logic [63:0] phase_rem(input logic [63:0] t, input logic [63:0] p,
                                             output logic neg);
      logic [63:0] d;
      logic [63:0] mag;
      logic [63:0] r;
      d   = t - origin_q;
      neg = d[63];
      mag = neg ? 64'd0 - d : d;
      r   = mag % p;
      return neg ? 64'd0 - r : r;
   endfunction

   function automatic tick_outcome_type advance_ticker(input logic [OP_W-1:0] op,
                                                       input logic [62:0] now_t,
                                                       input logic has_off,
                                                       input logic [62:0] offset);
      tick_outcome_type res;
      logic [63:0] now64;
      logic [63:0] p;
      logic [63:0] lead;
      logic [63:0] tt;
      logic [63:0] rem;
      logic [63:0] ttt;
      logic        neg;
      now64 = {1'b0, now_t};
      p     = eff_period();
      lead  = {1'b0, lead_reg};
      tt    = origin_q + p;
      res.tick_fired    = 1'b0;
      res.prewarn_fired = 1'b0;
      case (op)
         OP_CHECK: begin
            if (!slt(now64, tt)) begin
               res.tick_fired = ticker_en_q;
               rem      = phase_rem(now64, p, neg);
               origin_q = now64 - rem;
               tt       = origin_q + p;
            end else if (ticker_en_q && lead < p && !slt(now64, tt - lead)
                         && slt(warned_origin_q, origin_q)) begin
               res.prewarn_fired = 1'b1;
               warned_origin_q   = origin_q;
            end
         end
         OP_ON: begin
            if (has_off)
               origin_q = now64 - p + {1'b0, offset};
            else if (origin_q == '0)
               origin_q = now64;
            ticker_en_q = 1'b1;
            if (!slt(now64, origin_q + p - lead))
               warned_origin_q = origin_q;
            tt = origin_q + p;
         end
         OP_OFF: ticker_en_q = 1'b0;
         OP_RESTART: begin
            origin_q        = now64;
            warned_origin_q = '0;
            tt              = origin_q + p;
         end
         OP_RESYNC: begin
            warned_origin_q = slt(now64 - lead, origin_q) ? origin_q : 64'd0;
         end
         default: ;
      endcase

      rem = phase_rem(now64, p, neg);
      if (neg) begin
         ttt = p + (64'd0 - rem);
         if (ttt > TIME_MAX)
            ttt = TIME_MAX;
      end else begin
         ttt = p - rem;
      end

      if (ticker_en_q && lead < p && slt(lead, tt - now64))
         tt = tt - lead;
      res.next_deadline = tt[63] ? '0 : tt[62:0];
      res.time_to_tick  = ttt[62:0];
      res.ticker_on     = ticker_en_q;
      return res;
   endfunction

   function automatic logic [62:0] rand63();
      return 63'({$urandom, $urandom} >> 1);
   endfunction

   // ------------------------------------------------------------- drivers
   task automatic send_request(input logic [OP_W-1:0] op, input logic [62:0] now_t,
                               input logic has_off, input logic [62:0] offset);
      while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, offset, now_t};
      req_tuser  <= {has_off, op};
      do @(posedge clock); while (!req_tready);
      tick_outcomes_q.push_back(advance_ticker(op, now_t, has_off, offset));
      cur_now = now_t;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_PERIOD)
         period_reg = value;
      else
         lead_reg = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tick_outcomes_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_idle(input int gap_pct, input int stall_pct);
      sender_gap_pct = gap_pct;
      rsp_stall_pct  = stall_pct;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      fail_count++;
   endtask

   // -------------------------------------------------- receiver and checker
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left  = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      tick_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tick_outcomes_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[63:0], '0);
         end else begin
            want = tick_outcomes_q.pop_front();
            if (rsp_tdata[0] !== want.tick_fired)
               report_mismatch("tick_fired", 64'(rsp_tdata[0]), 64'(want.tick_fired));
            if (rsp_tdata[1] !== want.prewarn_fired)
               report_mismatch("prewarn_fired", 64'(rsp_tdata[1]),
                               64'(want.prewarn_fired));
            if (rsp_tdata[64:2] !== want.next_deadline)
               report_mismatch("next_deadline", 64'(rsp_tdata[64:2]),
                               64'(want.next_deadline));
            if (rsp_tdata[127:65] !== want.time_to_tick)
               report_mismatch("time_to_tick", 64'(rsp_tdata[127:65]),
                               64'(want.time_to_tick));
            if (rsp_tdata[128] !== want.ticker_on)
               report_mismatch("ticker_on", 64'(rsp_tdata[128]), 64'(want.ticker_on));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests
   // opcodes and special cases under the reset configuration
   task automatic test_directed_ops();
      logic [63:0] tick_at;
      send_request(OP_QUERY, '0, 1'b0, '0);
      send_request(OP_CHECK, '0, 1'b1, TIME_MAX[62:0]);
      send_request(OP_CHECK, TIME_MAX[62:0], 1'b0, '0);      // tick reached while off
      send_request(OP_SPARE_A, rand63(), 1'b1, rand63());
      send_request(OP_SPARE_B, rand63(), 1'b0, rand63());
      send_request(OP_RESTART, 63'd1000, 1'b0, '0);
      send_request(OP_RESYNC, 63'd500, 1'b0, '0);
      send_request(OP_RESYNC, TIME_MAX[62:0], 1'b0, '0);
      send_request(OP_ON, 63'd7777, 1'b0, '0);               // origin kept
      send_request(OP_RESTART, '0, 1'b0, '0);
      send_request(OP_ON, 63'd12345, 1'b0, '0);              // zero origin takes now
      send_request(OP_ON, '0, 1'b1, TIME_MAX[62:0]);
      send_request(OP_ON, 63'd99, 1'b1, '0);
      send_request(OP_OFF, 63'd100, 1'b0, '0);
      tick_at = origin_q + eff_period();
      send_request(OP_CHECK, tick_at[62:0], 1'b0, '0);
      wait_drained();
   endtask

   task automatic test_register_extremes();
      write_reg(REG_PERIOD, '0);                              // acts as one
      write_reg(REG_LEAD, '0);
      send_request(OP_RESTART, 63'd5, 1'b0, '0);
      send_request(OP_ON, 63'd5, 1'b0, '0);
      send_request(OP_CHECK, 63'd9, 1'b0, '0);
      wait_drained();
      write_reg(REG_PERIOD, TIME_MAX[62:0]);
      write_reg(REG_LEAD, TIME_MAX[62:0]);                    // lead not below period
      send_request(OP_RESTART, '0, 1'b0, '0);
      send_request(OP_ON, '0, 1'b0, '0);
      send_request(OP_CHECK, TIME_MAX[62:0], 1'b0, '0);
      send_request(OP_QUERY, 63'd1, 1'b0, '0);
      wait_drained();
      write_reg(REG_PERIOD, 63'd1000);
      write_reg(REG_LEAD, 63'd100);
      send_request(OP_RESTART, '0, 1'b0, '0);
      send_request(OP_ON, '0, 1'b0, '0);
      send_request(OP_CHECK, 63'd900, 1'b0, '0);              // warning edge, no pre-warning at a zero origin
      send_request(OP_CHECK, 63'd1000, 1'b0, '0);             // tick
      wait_drained();
   endtask

   // well-formed runs: times chosen around tick and warning edges
   task automatic run_tick_sequence(input int n_items);
      logic [63:0] p;
      logic [63:0] lead;
      logic [63:0] target;
      logic [OP_W-1:0] op;
      logic [62:0] base;
      if ($urandom_range(4) == 0)
         p = {24'd0, 8'($urandom_range(255)), $urandom} + 64'd1;
      else
         p = 64'($urandom_range(5000, 1));
      case ($urandom_range(5))
         0:       lead = '0;
         1:       lead = p;
         2:       lead = p + 64'($urandom_range(1000));
         default: lead = {1'b0, rand63()} % p;
      endcase
      write_reg(REG_PERIOD, p[62:0]);
      write_reg(REG_LEAD, lead[62:0]);
      base = ($urandom_range(1) == 0) ? rand63() >> 2 : 63'($urandom_range(100000));
      send_request(OP_RESTART, base, 1'b0, rand63());
      send_request(OP_ON, base, 1'($urandom_range(1)), 63'({1'b0, rand63()} % p));
      for (int i = 0; i < n_items; i++) begin
         case ($urandom_range(9))
            0:       target = origin_q + p;
            1:       target = origin_q + p - lead;
            2:       target = origin_q + p - lead - 64'd1;
            3:       target = origin_q + p - 64'd1;
            8:       target = {1'b0, cur_now} + p * 64'($urandom_range(5))
                              + {1'b0, rand63()} % p;
            9:       target = {1'b0, cur_now};
            default: target = {1'b0, cur_now} + {1'b0, rand63()} % (p / 4 + 64'd1);
         endcase
         case ($urandom_range(99)) inside
            [0:59]:  op = OP_CHECK;
            [60:69]: op = OP_QUERY;
            [70:77]: op = OP_RESYNC;
            [78:84]: op = OP_ON;
            [85:89]: op = OP_OFF;
            [90:94]: op = OP_RESTART;
            default: op = ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
         endcase
         send_request(op, target[62:0], 1'($urandom_range(1)),
                      ($urandom_range(3) == 0) ? rand63() : 63'({1'b0, rand63()} % p));
      end
      wait_drained();
   endtask

   // output held off while the sender keeps offering
   task automatic test_backpressure();
      write_reg(REG_PERIOD, 63'd2000);
      write_reg(REG_LEAD, 63'd300);
      send_request(OP_RESTART, 63'd50000, 1'b0, '0);
      send_request(OP_ON, 63'd50000, 1'b0, '0);
      hold_start = 1'b1;
      for (int i = 0; i < 10; i++)
         send_request(OP_CHECK, cur_now + 63'($urandom_range(900)), 1'b0, '0);
      wait_drained();
   endtask

   // unconstrained requests over the full field ranges
   task automatic run_noise(input int seg, input int n_items);
      case (seg)
         0:       write_reg(REG_PERIOD, 63'd1);
         1:       write_reg(REG_PERIOD, TIME_MAX[62:0]);
         default: write_reg(REG_PERIOD, rand63());
      endcase
      write_reg(REG_LEAD, ($urandom_range(1) == 0) ? rand63() : 63'($urandom));
      for (int i = 0; i < n_items; i++)
         send_request(3'($urandom_range(7)), rand63(), 1'($urandom_range(1)), rand63());
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idle(0, 0);
      test_directed_ops();
      test_register_extremes();
      for (int m = 0; m < 4; m++) begin
         set_idle(gap_modes[m], stall_modes[m]);
         repeat (5) run_tick_sequence(32);
      end
      set_idle(0, 0);
      test_backpressure();
      for (int m = 0; m < 4; m++) begin
         set_idle(gap_modes[m], stall_modes[m]);
         run_noise(m, 40);
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (tick_outcomes_q.size() != 0)
         report_mismatch("responses missing", 64'(tick_outcomes_q.size()), 64'd0);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
